### rtl/lfsc_pkg.sv
// Shared types and constants of the line-follow steering controller.
// Used by every module of the block but lfsc_steer; depends on nothing else.
package lfsc_pkg;

    localparam int MAX_SPEED_DEFAULT  = 127;
    localparam int DRIFT_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEER_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAIGHT_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_STEP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_CAP = 3'd5;

    localparam logic [6:0] BASE_SPEED_RESET     = 7'd0;
    localparam logic [7:0] STEER_GAIN_RESET     = 8'd80;
    localparam logic [9:0] STRAIGHT_LIMIT_RESET = 10'd50;
    localparam logic [9:0] TURN_LIMIT_RESET     = 10'd400;
    localparam logic [7:0] EDGE_STEP_RESET      = 8'd4;
    localparam logic [6:0] CORRECTION_CAP_RESET = 7'd64;

    localparam logic [2:0] ACT_FOLLOW   = 3'd0;
    localparam logic [2:0] ACT_LEFT     = 3'd1;
    localparam logic [2:0] ACT_RIGHT    = 3'd2;
    localparam logic [2:0] ACT_CW       = 3'd3;
    localparam logic [2:0] ACT_CCW      = 3'd4;
    localparam logic [2:0] ACT_DELIVERY = 3'd5;
    localparam logic [2:0] ACT_QUERY    = 3'd6;

    localparam logic [2:0] ST_BUSY  = 3'd0;
    localparam logic [2:0] ST_DONE  = 3'd1;
    localparam logic [2:0] ST_LOST  = 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_RIGHT = 3'd4;
    localparam logic [2:0] ST_BOTH  = 3'd5;
    localparam logic [2:0] ST_NONE  = 3'd6;

    typedef struct packed {
        logic [6:0] base_speed;
        logic [7:0] steer_gain;
        logic [9:0] straight_lost_limit;
        logic [9:0] turn_lost_limit;
        logic [7:0] edge_step;
        logic [6:0] correction_cap;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic       inner_left;
        logic       inner_right;
        logic       edge_left;
        logic       edge_right;
        logic [7:0] lines_to_skip;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       drive_valid;
        logic [6:0] left_drive;
        logic       left_reverse;
        logic [6:0] right_drive;
        logic       right_reverse;
    } result_t;

endpackage

### rtl/lfsc_cfg_regs.sv
// Configuration register file of the line-follow steering controller.
// Depends on lfsc_pkg for the register indexes, reset values and cfg_t.
module lfsc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_enable,
    input  logic [lfsc_pkg::CFG_INDEX_W-1:0]   reg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]    write_data,
    output lfsc_pkg::cfg_t                     cfg
);

    lfsc_pkg::cfg_t cfg_reg;
    lfsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index)
                lfsc_pkg::REG_BASE_SPEED:     cfg_next.base_speed          = write_data[6:0];
                lfsc_pkg::REG_STEER_GAIN:     cfg_next.steer_gain          = write_data[7:0];
                lfsc_pkg::REG_STRAIGHT_LIMIT: cfg_next.straight_lost_limit = write_data[9:0];
                lfsc_pkg::REG_TURN_LIMIT:     cfg_next.turn_lost_limit     = write_data[9:0];
                lfsc_pkg::REG_EDGE_STEP:      cfg_next.edge_step           = write_data[7:0];
                lfsc_pkg::REG_CORRECTION_CAP: cfg_next.correction_cap      = write_data[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed          <= lfsc_pkg::BASE_SPEED_RESET;
            cfg_reg.steer_gain          <= lfsc_pkg::STEER_GAIN_RESET;
            cfg_reg.straight_lost_limit <= lfsc_pkg::STRAIGHT_LIMIT_RESET;
            cfg_reg.turn_lost_limit     <= lfsc_pkg::TURN_LIMIT_RESET;
            cfg_reg.edge_step           <= lfsc_pkg::EDGE_STEP_RESET;
            cfg_reg.correction_cap      <= lfsc_pkg::CORRECTION_CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lfsc_steer.sv
// Wheel correction of the line-follow steering controller: drift times gain,
// capped, spent on headroom first and then taken from the other wheel.
// Depends on lfsc_pkg only through the parameter defaults of the top level.
module lfsc_steer #(
    parameter int MAX_SPEED  = 127,
    parameter int DRIFT_BITS = 16
) (
    input  logic [DRIFT_BITS-1:0] left_drift,
    input  logic [DRIFT_BITS-1:0] right_drift,
    input  logic [6:0]            speed,
    input  logic [7:0]            steer_gain,
    input  logic [6:0]            correction_cap,
    output logic [6:0]            left_drive,
    output logic [6:0]            right_drive
);

    localparam int SPW = $clog2(MAX_SPEED + 1);
    localparam int SW  = (SPW > 7) ? SPW : 7;
    localparam logic [SW-1:0] MAX_W = SW'(MAX_SPEED);

    logic [DRIFT_BITS-1:0] err;
    logic [DRIFT_BITS+7:0] product;
    logic [DRIFT_BITS+3:0] corr_full;
    logic [6:0]            corr;
    logic [SW-1:0]         sp_w;
    logic [SW-1:0]         corr_w;
    logic [SW-1:0]         head;
    logic [SW-1:0]         over;
    logic [SW-1:0]         fav;
    logic [SW-1:0]         oth;
    logic [6:0]            fav_clip;

    always_comb
    begin
        err       = (left_drift != '0) ? left_drift : right_drift;
        product   = err * steer_gain;
        corr_full = product[DRIFT_BITS+7:4];
        corr      = (corr_full > (DRIFT_BITS+4)'(correction_cap)) ?
                    correction_cap : corr_full[6:0];
        sp_w      = SW'(speed);
        corr_w    = SW'(corr);
        head      = MAX_W - sp_w;
        over      = corr_w - head;
        if (head >= corr_w)
        begin
            fav = sp_w + corr_w;
            oth = sp_w;
        end
        else
        begin
            fav = MAX_W;
            oth = (over > sp_w) ? '0 : sp_w - over;
        end
        fav_clip = (fav > SW'(127)) ? 7'd127 : fav[6:0];
        if (left_drift != '0)
        begin
            left_drive  = fav_clip;
            right_drive = oth[6:0];
        end
        else
        begin
            left_drive  = oth[6:0];
            right_drive = fav_clip;
        end
    end

endmodule

### rtl/lfsc_tick.sv
// Control-tick logic: sensor classification, drift and lost counters,
// turn line counting and the result of one item. Holds the tracking state.
// Depends on lfsc_pkg and instantiates lfsc_steer.
module lfsc_tick #(
    parameter int MAX_SPEED  = 127,
    parameter int DRIFT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lfsc_pkg::item_t     item,
    input  lfsc_pkg::cfg_t      cfg,
    output lfsc_pkg::result_t   result
);

    localparam int SPW = $clog2(MAX_SPEED + 1);
    localparam int SW  = (SPW > 7) ? SPW : 7;
    localparam logic [SW-1:0] MAX_W = SW'(MAX_SPEED);

    logic [DRIFT_BITS-1:0] left_drift_reg,  left_drift_next;
    logic [DRIFT_BITS-1:0] right_drift_reg, right_drift_next;
    logic [15:0]           no_line_reg,     no_line_next;
    logic                  turn_line_reg,   turn_line_next;
    logic [7:0]            skipped_reg,     skipped_next;

    logic [3:0]            sense;
    logic [7:0]            l_inc;
    logic [7:0]            r_inc;
    logic [DRIFT_BITS:0]   l_sum;
    logic [DRIFT_BITS:0]   r_sum;
    logic [DRIFT_BITS-1:0] l_sat;
    logic [DRIFT_BITS-1:0] r_sat;
    logic [15:0]           no_line_inc;
    logic [SW-1:0]         base_w;
    logic [6:0]            speed;
    logic [6:0]            half;
    logic [2:0]            dir;
    logic [7:0]            skip;
    logic                  on_line;
    logic [6:0]            steer_left;
    logic [6:0]            steer_right;
    lfsc_pkg::result_t     res;

    lfsc_steer #(
        .MAX_SPEED  (MAX_SPEED),
        .DRIFT_BITS (DRIFT_BITS)
    ) u_steer (
        .left_drift     (left_drift_next),
        .right_drift    (right_drift_next),
        .speed          (speed),
        .steer_gain     (cfg.steer_gain),
        .correction_cap (cfg.correction_cap),
        .left_drive     (steer_left),
        .right_drive    (steer_right)
    );

    always_comb
    begin
        sense       = {item.inner_left, item.inner_right, item.edge_left, item.edge_right};
        l_inc       = (sense == 4'b0001) ? cfg.edge_step : 8'd1;
        r_inc       = (sense == 4'b0010) ? cfg.edge_step : 8'd1;
        l_sum       = {1'b0, left_drift_reg} + (DRIFT_BITS+1)'(l_inc);
        r_sum       = {1'b0, right_drift_reg} + (DRIFT_BITS+1)'(r_inc);
        l_sat       = l_sum[DRIFT_BITS] ? '1 : l_sum[DRIFT_BITS-1:0];
        r_sat       = r_sum[DRIFT_BITS] ? '1 : r_sum[DRIFT_BITS-1:0];
        no_line_inc = (no_line_reg == 16'hFFFF) ? no_line_reg : no_line_reg + 16'd1;
        base_w      = SW'(cfg.base_speed);
        speed       = (base_w > MAX_W) ? MAX_W[6:0] : cfg.base_speed;
        half        = speed >> 1;
        dir         = (item.action == lfsc_pkg::ACT_DELIVERY) ? lfsc_pkg::ACT_CW : item.action;
        skip        = (item.action == lfsc_pkg::ACT_DELIVERY) ? 8'd0 : item.lines_to_skip;
        on_line     = 1'b0;

        left_drift_next  = left_drift_reg;
        right_drift_next = right_drift_reg;
        no_line_next     = no_line_reg;
        turn_line_next   = turn_line_reg;
        skipped_next     = skipped_reg;
        res              = '0;
        res.status       = lfsc_pkg::ST_BUSY;

        case (item.action)
            lfsc_pkg::ACT_FOLLOW:
            begin
                turn_line_next = 1'b0;
                skipped_next   = 8'd0;
                if (sense == 4'b1100)
                begin
                    left_drift_next  = '0;
                    right_drift_next = '0;
                    no_line_next     = '0;
                end
                else if (sense == 4'b0100 || sense == 4'b0001)
                begin
                    left_drift_next  = l_sat;
                    right_drift_next = '0;
                    no_line_next     = '0;
                end
                else if (sense == 4'b1000 || sense == 4'b0010)
                begin
                    right_drift_next = r_sat;
                    left_drift_next  = '0;
                    no_line_next     = '0;
                end
                else if (item.inner_left && item.inner_right && item.edge_left)
                begin
                    left_drift_next  = '0;
                    right_drift_next = '0;
                    no_line_next     = '0;
                    res.status = item.edge_right ? lfsc_pkg::ST_BOTH : lfsc_pkg::ST_LEFT;
                end
                else if (item.inner_left && item.inner_right && item.edge_right)
                begin
                    left_drift_next  = '0;
                    right_drift_next = '0;
                    no_line_next     = '0;
                    res.status       = lfsc_pkg::ST_RIGHT;
                end
                else if (sense == 4'b0000)
                begin
                    if (no_line_inc > 16'(cfg.straight_lost_limit))
                    begin
                        res.status = lfsc_pkg::ST_LOST;
                    end
                    else
                    begin
                        no_line_next = no_line_inc;
                        if (left_drift_reg != '0)
                        begin
                            left_drift_next = l_sat;
                        end
                        else if (right_drift_reg != '0)
                        begin
                            right_drift_next = r_sat;
                        end
                    end
                end
                res.drive_valid = 1'b1;
                res.left_drive  = steer_left;
                res.right_drive = steer_right;
            end

            lfsc_pkg::ACT_LEFT, lfsc_pkg::ACT_RIGHT, lfsc_pkg::ACT_CW,
            lfsc_pkg::ACT_CCW, lfsc_pkg::ACT_DELIVERY:
            begin
                res.drive_valid = 1'b1;
                case (dir)
                    lfsc_pkg::ACT_LEFT:
                    begin
                        res.right_drive = speed;
                    end
                    lfsc_pkg::ACT_RIGHT:
                    begin
                        res.left_drive = speed;
                    end
                    lfsc_pkg::ACT_CW:
                    begin
                        res.left_drive    = half;
                        res.right_drive   = half;
                        res.right_reverse = 1'b1;
                    end
                    default:
                    begin
                        res.left_drive    = half;
                        res.right_drive   = half;
                        res.left_reverse  = 1'b1;
                    end
                endcase

                if (sense == 4'b1100)
                begin
                    on_line = 1'b1;
                end
                else if (dir == lfsc_pkg::ACT_LEFT || dir == lfsc_pkg::ACT_CCW)
                begin
                    on_line = item.inner_left && !item.inner_right;
                end
                else if (dir == lfsc_pkg::ACT_RIGHT)
                begin
                    on_line = !item.inner_left && item.inner_right;
                end
                else
                begin
                    on_line = item.edge_right;
                end

                if (sense == 4'b0000)
                begin
                    turn_line_next = 1'b1;
                    if (no_line_inc > 16'(cfg.turn_lost_limit))
                    begin
                        res.status = lfsc_pkg::ST_LOST;
                    end
                    else
                    begin
                        no_line_next = no_line_inc;
                    end
                end
                else if (on_line && turn_line_reg)
                begin
                    turn_line_next = 1'b0;
                    if (skipped_reg < skip)
                    begin
                        skipped_next = skipped_reg + 8'd1;
                    end
                    else
                    begin
                        skipped_next = 8'd0;
                        res.status   = lfsc_pkg::ST_DONE;
                    end
                end

                if (item.action == lfsc_pkg::ACT_DELIVERY && turn_line_next)
                begin
                    turn_line_next = 1'b0;
                    no_line_next   = '0;
                    res.status     = lfsc_pkg::ST_DONE;
                end
            end

            lfsc_pkg::ACT_QUERY:
            begin
                if (!item.inner_left || !item.inner_right)
                begin
                    res.status = lfsc_pkg::ST_NONE;
                end
                else if (item.edge_left && item.edge_right)
                begin
                    res.status = lfsc_pkg::ST_BOTH;
                end
                else if (item.edge_left)
                begin
                    res.status = lfsc_pkg::ST_LEFT;
                end
                else if (item.edge_right)
                begin
                    res.status = lfsc_pkg::ST_RIGHT;
                end
                else
                begin
                    res.status = lfsc_pkg::ST_NONE;
                end
            end

            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_drift_reg  <= '0;
            right_drift_reg <= '0;
            no_line_reg     <= '0;
            turn_line_reg   <= 1'b0;
            skipped_reg     <= '0;
        end
        else if (fire)
        begin
            left_drift_reg  <= left_drift_next;
            right_drift_reg <= right_drift_next;
            no_line_reg     <= no_line_next;
            turn_line_reg   <= turn_line_next;
            skipped_reg     <= skipped_next;
        end
    end

    assign result = res;

endmodule

### rtl/line_follow_steering_controller.sv
// Line-follow steering controller: one control tick per item, producing a
// status and both wheel drives. Top level with the input and result registers.
// Depends on lfsc_pkg, lfsc_cfg_regs, lfsc_steer and lfsc_tick.
//
// Items arrive on the item channel (item_valid/item_ready) and carry an
// action, four line-sensor bits and a line count for turns. Every item gives
// exactly one result on the result channel (result_valid/result_ready).
// An accepted item is held in an input register, is processed once the
// result register is empty or being read, and lands in the result register.
// While result_ready stays high a new item can be taken in every cycle,
// so the sustained rate is one item per clock; the tracking counters are
// updated in the same cycle that a result is written.
// Configuration is written through write_enable, reg_index and write_data
// and should only be changed while no item is in flight.
// Reset clears the tracking counters, empties both registers and loads the
// default configuration. When the receiver holds result_ready low the result
// stays put, at most one further item is accepted into the input register, and then
// item_ready falls until the result is taken.
module line_follow_steering_controller #(
    parameter int MAX_SPEED  = lfsc_pkg::MAX_SPEED_DEFAULT,
    parameter int DRIFT_BITS = lfsc_pkg::DRIFT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [lfsc_pkg::CFG_INDEX_W-1:0] reg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]  write_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [2:0]                       action,
    input  logic                             inner_left,
    input  logic                             inner_right,
    input  logic                             edge_left,
    input  logic                             edge_right,
    input  logic [7:0]                       lines_to_skip,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [2:0]                       status,
    output logic                             drive_valid,
    output logic [6:0]                       left_drive,
    output logic                             left_reverse,
    output logic [6:0]                       right_drive,
    output logic                             right_reverse
);

    lfsc_pkg::cfg_t    cfg;
    lfsc_pkg::item_t   item_reg,       item_next;
    logic              item_full_reg,  item_full_next;
    lfsc_pkg::result_t result_reg,     result_next;
    logic              result_full_reg, result_full_next;
    lfsc_pkg::result_t tick_result;
    logic              advance;
    logic              accept;
    logic              fire;

    lfsc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .cfg          (cfg)
    );

    lfsc_tick #(
        .MAX_SPEED  (MAX_SPEED),
        .DRIFT_BITS (DRIFT_BITS)
    ) u_tick (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (tick_result)
    );

    assign advance    = !result_full_reg || result_ready;
    assign item_ready = !item_full_reg || advance;
    assign accept     = item_valid && item_ready;
    assign fire       = item_full_reg && advance;

    always_comb
    begin
        item_next        = item_reg;
        item_full_next   = item_full_reg;
        result_next      = result_reg;
        result_full_next = result_full_reg;
        if (advance)
        begin
            result_full_next = item_full_reg;
            item_full_next   = 1'b0;
        end
        if (fire)
        begin
            result_next = tick_result;
        end
        if (accept)
        begin
            item_full_next          = 1'b1;
            item_next.action        = action;
            item_next.inner_left    = inner_left;
            item_next.inner_right   = inner_right;
            item_next.edge_left     = edge_left;
            item_next.edge_right    = edge_right;
            item_next.lines_to_skip = lines_to_skip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg   <= 1'b0;
            result_full_reg <= 1'b0;
        end
        else
        begin
            item_full_reg   <= item_full_next;
            result_full_reg <= result_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign result_valid  = result_full_reg;
    assign status        = result_reg.status;
    assign drive_valid   = result_reg.drive_valid;
    assign left_drive    = result_reg.left_drive;
    assign left_reverse  = result_reg.left_reverse;
    assign right_drive   = result_reg.right_drive;
    assign right_reverse = result_reg.right_reverse;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid && !result_ready && item_full_reg))
        else $error("item_ready low while the result register can drain");

    a_idle_wheels_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !drive_valid) |->
        (left_drive == 7'd0 && right_drive == 7'd0 && !left_reverse && !right_reverse))
        else $error("wheel fields driven on a result without drive");

    a_one_wheel_reversed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(left_reverse && right_reverse))
        else $error("both wheels reversed at once");

    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("processed item did not reach the result register");

endmodule

### bench/tb_line_follow_steering_controller.sv
// Self-checking testbench for line_follow_steering_controller: directed and random control
// ticks under several register settings, each result checked against an in-bench predictor.
// Depends on lfsc_pkg and the controller RTL only.
module tb_line_follow_steering_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPEED_CEILING = lfsc_pkg::MAX_SPEED_DEFAULT;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [3:0] SENS_CLEAR      = 4'b0000;
    localparam logic [3:0] SENS_CENTRE     = 4'b1100;
    localparam logic [3:0] SENS_INNER_L    = 4'b1000;
    localparam logic [3:0] SENS_INNER_R    = 4'b0100;
    localparam logic [3:0] SENS_EDGE_L     = 4'b0010;
    localparam logic [3:0] SENS_EDGE_R     = 4'b0001;
    localparam logic [3:0] SENS_JUNCTION_L = 4'b1110;
    localparam logic [3:0] SENS_JUNCTION_R = 4'b1101;
    localparam logic [3:0] SENS_ALL        = 4'b1111;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             write_enable = 1'b0;
    logic [lfsc_pkg::CFG_INDEX_W-1:0] reg_index = '0;
    logic [lfsc_pkg::CFG_DATA_W-1:0]  write_data = '0;
    logic                             item_valid = 1'b0;
    logic                             item_ready;
    logic [2:0]                       action = '0;
    logic                             inner_left = 1'b0;
    logic                             inner_right = 1'b0;
    logic                             edge_left = 1'b0;
    logic                             edge_right = 1'b0;
    logic [7:0]                       lines_to_skip = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    logic [2:0]                       status;
    logic                             drive_valid;
    logic [6:0]                       left_drive;
    logic                             left_reverse;
    logic [6:0]                       right_drive;
    logic                             right_reverse;

    lfsc_pkg::item_t   pending_ticks[$];
    lfsc_pkg::result_t expected_results[$];
    logic    tick_taken = 1'b0;
    int      ticks_queued = 0;
    int      results_seen = 0;
    int      errors = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    int      next_hold_at = 150;

    lfsc_pkg::cfg_t cfg_model;
    logic [15:0]    drift_l = '0;
    logic [15:0]    drift_r = '0;
    logic [15:0]    blind_ticks = '0;
    logic           line_gap = 1'b0;
    logic [7:0]     crossed = '0;

    line_follow_steering_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_enable  (write_enable),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .inner_left    (inner_left),
        .inner_right   (inner_right),
        .edge_left     (edge_left),
        .edge_right    (edge_right),
        .lines_to_skip (lines_to_skip),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .drive_valid   (drive_valid),
        .left_drive    (left_drive),
        .left_reverse  (left_reverse),
        .right_drive   (right_drive),
        .right_reverse (right_reverse)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] value, int step);
        int sum;
        sum = int'(value) + step;
        return (sum > 16'hFFFF) ? 16'hFFFF : 16'(sum);
    endfunction

    function automatic int cruise_speed();
        return (int'(cfg_model.base_speed) < SPEED_CEILING) ? int'(cfg_model.base_speed)
                                                            : SPEED_CEILING;
    endfunction

    function automatic lfsc_pkg::result_t wheel_drive(int left_speed, logic left_rev,
                                                      int right_speed, logic right_rev);
        lfsc_pkg::result_t r;
        r = '0;
        r.drive_valid   = 1'b1;
        r.left_drive    = (left_speed > 127) ? 7'd127 : 7'(left_speed);
        r.left_reverse  = left_rev;
        r.right_drive   = (right_speed > 127) ? 7'd127 : 7'(right_speed);
        r.right_reverse = right_rev;
        return r;
    endfunction

    function automatic lfsc_pkg::result_t steer_wheels();
        int sp;
        int headroom;
        int drift;
        int corr;
        int fast;
        int slow;
        sp = cruise_speed();
        headroom = SPEED_CEILING - sp;
        drift = (drift_l != 0) ? int'(drift_l) : int'(drift_r);
        if (drift == 0)
            return wheel_drive(sp, 1'b0, sp, 1'b0);
        corr = (drift * int'(cfg_model.steer_gain)) >>> 4;
        if (corr > int'(cfg_model.correction_cap))
            corr = int'(cfg_model.correction_cap);
        if (headroom >= corr)
        begin
            fast = sp + corr;
            slow = sp;
        end
        else
        begin
            fast = sp + headroom;
            slow = (corr - headroom > sp) ? 0 : sp - (corr - headroom);
        end
        if (drift_l != 0)
            return wheel_drive(fast, 1'b0, slow, 1'b0);
        return wheel_drive(slow, 1'b0, fast, 1'b0);
    endfunction

    function automatic lfsc_pkg::result_t follow_tick(logic [3:0] s);
        logic              il;
        logic              ir;
        logic              el;
        logic              er;
        logic [2:0]        st;
        logic [15:0]       t;
        lfsc_pkg::result_t r;
        {il, ir, el, er} = s;
        st = lfsc_pkg::ST_BUSY;
        line_gap = 1'b0;
        crossed = '0;
        if (s == SENS_CENTRE)
        begin
            drift_l = '0;
            drift_r = '0;
            blind_ticks = '0;
        end
        else if (s == SENS_INNER_R)
        begin
            drift_l = sat_inc(drift_l, 1);
            drift_r = '0;
            blind_ticks = '0;
        end
        else if (s == SENS_INNER_L)
        begin
            drift_r = sat_inc(drift_r, 1);
            drift_l = '0;
            blind_ticks = '0;
        end
        else if (s == SENS_EDGE_L)
        begin
            drift_r = sat_inc(drift_r, int'(cfg_model.edge_step));
            drift_l = '0;
            blind_ticks = '0;
        end
        else if (s == SENS_EDGE_R)
        begin
            drift_l = sat_inc(drift_l, int'(cfg_model.edge_step));
            drift_r = '0;
            blind_ticks = '0;
        end
        else if (il && ir && el)
        begin
            drift_l = '0;
            drift_r = '0;
            blind_ticks = '0;
            st = er ? lfsc_pkg::ST_BOTH : lfsc_pkg::ST_LEFT;
        end
        else if (il && ir && er)
        begin
            drift_l = '0;
            drift_r = '0;
            blind_ticks = '0;
            st = lfsc_pkg::ST_RIGHT;
        end
        else if (s == SENS_CLEAR)
        begin
            t = sat_inc(blind_ticks, 1);
            if (t > cfg_model.straight_lost_limit)
                st = lfsc_pkg::ST_LOST;
            else
            begin
                blind_ticks = t;
                if (drift_l != 0)
                    drift_l = sat_inc(drift_l, 1);
                else if (drift_r != 0)
                    drift_r = sat_inc(drift_r, 1);
            end
        end
        r = steer_wheels();
        r.status = st;
        return r;
    endfunction

    function automatic lfsc_pkg::result_t turn_tick(logic [2:0] dir, logic [3:0] s,
                                                    logic [7:0] skip);
        int                sp;
        logic              il;
        logic              ir;
        logic              el;
        logic              er;
        logic              on_line;
        logic [15:0]       t;
        lfsc_pkg::result_t r;
        sp = cruise_speed();
        {il, ir, el, er} = s;
        case (dir)
            lfsc_pkg::ACT_LEFT:  r = wheel_drive(0, 1'b0, sp, 1'b0);
            lfsc_pkg::ACT_RIGHT: r = wheel_drive(sp, 1'b0, 0, 1'b0);
            lfsc_pkg::ACT_CW:    r = wheel_drive(sp / 2, 1'b0, sp / 2, 1'b1);
            default:             r = wheel_drive(sp / 2, 1'b1, sp / 2, 1'b0);
        endcase
        r.status = lfsc_pkg::ST_BUSY;
        if (s == SENS_CLEAR)
        begin
            line_gap = 1'b1;
            t = sat_inc(blind_ticks, 1);
            if (t > cfg_model.turn_lost_limit)
                r.status = lfsc_pkg::ST_LOST;
            else
                blind_ticks = t;
            return r;
        end
        if (s == SENS_CENTRE)
            on_line = 1'b1;
        else if (dir == lfsc_pkg::ACT_LEFT || dir == lfsc_pkg::ACT_CCW)
            on_line = il && !ir;
        else if (dir == lfsc_pkg::ACT_RIGHT)
            on_line = !il && ir;
        else
            on_line = er;
        if (on_line && line_gap)
        begin
            line_gap = 1'b0;
            if (crossed < skip)
                crossed = crossed + 8'd1;
            else
            begin
                crossed = '0;
                r.status = lfsc_pkg::ST_DONE;
            end
        end
        return r;
    endfunction

    function automatic lfsc_pkg::result_t predict_tick(lfsc_pkg::item_t it);
        logic [3:0]        s;
        lfsc_pkg::result_t r;
        s = {it.inner_left, it.inner_right, it.edge_left, it.edge_right};
        r = '0;
        case (it.action)
            lfsc_pkg::ACT_FOLLOW:
                r = follow_tick(s);
            lfsc_pkg::ACT_LEFT, lfsc_pkg::ACT_RIGHT, lfsc_pkg::ACT_CW, lfsc_pkg::ACT_CCW:
                r = turn_tick(it.action, s, it.lines_to_skip);
            lfsc_pkg::ACT_DELIVERY:
            begin
                r = turn_tick(lfsc_pkg::ACT_CW, s, 8'd0);
                if (line_gap)
                begin
                    line_gap = 1'b0;
                    blind_ticks = '0;
                    r.status = lfsc_pkg::ST_DONE;
                end
            end
            lfsc_pkg::ACT_QUERY:
            begin
                if (!it.inner_left || !it.inner_right)
                    r.status = lfsc_pkg::ST_NONE;
                else if (it.edge_left && it.edge_right)
                    r.status = lfsc_pkg::ST_BOTH;
                else if (it.edge_left)
                    r.status = lfsc_pkg::ST_LEFT;
                else if (it.edge_right)
                    r.status = lfsc_pkg::ST_RIGHT;
                else
                    r.status = lfsc_pkg::ST_NONE;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("line_follow_steering_controller verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        lfsc_pkg::result_t want;
        lfsc_pkg::item_t   seen;
        if (!rst_n)
            tick_taken <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, status %0d", $time, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("drive_valid", want.drive_valid, drive_valid);
                    compare_field("left_drive", want.left_drive, left_drive);
                    compare_field("left_reverse", want.left_reverse, left_reverse);
                    compare_field("right_drive", want.right_drive, right_drive);
                    compare_field("right_reverse", want.right_reverse, right_reverse);
                end
            end
            if (item_valid && item_ready)
            begin
                seen.action        = action;
                seen.inner_left    = inner_left;
                seen.inner_right   = inner_right;
                seen.edge_left     = edge_left;
                seen.edge_right    = edge_right;
                seen.lines_to_skip = lines_to_skip;
                expected_results.push_back(predict_tick(seen));
            end
            tick_taken <= item_valid && item_ready;
        end
    end

    always @(negedge clk)
    begin
        if (tick_taken)
            pending_ticks.delete(0);
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || tick_taken)
        begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid    <= 1'b1;
                action        <= pending_ticks[0].action;
                inner_left    <= pending_ticks[0].inner_left;
                inner_right   <= pending_ticks[0].inner_right;
                edge_left     <= pending_ticks[0].edge_left;
                edge_right    <= pending_ticks[0].edge_right;
                lines_to_skip <= pending_ticks[0].lines_to_skip;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // The receiver stops now and then for a long stretch so that the block fills up.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (hold_left != 0)
                hold_left = hold_left - 1;
            else if (results_seen >= next_hold_at)
            begin
                hold_left = 48;
                next_hold_at = next_hold_at + 300;
            end
            result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_tick(logic [2:0] act, logic [3:0] sensors, logic [7:0] skip);
        lfsc_pkg::item_t t;
        t.action = act;
        {t.inner_left, t.inner_right, t.edge_left, t.edge_right} = sensors;
        t.lines_to_skip = skip;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    function automatic logic [3:0] follow_pattern();
        logic [3:0] s;
        case ($urandom_range(11))
            0:       s = SENS_CENTRE;
            1:       s = SENS_INNER_R;
            2:       s = SENS_INNER_L;
            3:       s = SENS_EDGE_L;
            4:       s = SENS_EDGE_R;
            5:       s = SENS_JUNCTION_L;
            6:       s = SENS_ALL;
            7:       s = SENS_JUNCTION_R;
            8, 9:    s = SENS_CLEAR;
            default: s = 4'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [3:0] line_ahead(logic [2:0] dir);
        logic [1:0] edges;
        edges = 2'($urandom);
        if ($urandom_range(5) == 0)
            return SENS_CENTRE;
        case (dir)
            lfsc_pkg::ACT_LEFT, lfsc_pkg::ACT_CCW: return {2'b10, edges};
            lfsc_pkg::ACT_RIGHT:                   return {2'b01, edges};
            default:                               return {2'($urandom), edges[1], 1'b1};
        endcase
    endfunction

    task automatic add_sequence();
        int         passes;
        logic [2:0] dir;
        logic [7:0] skip;
        case ($urandom_range(9))
            0, 1, 2:
                repeat ($urandom_range(16, 4))
                    add_tick(lfsc_pkg::ACT_FOLLOW, follow_pattern(), 8'($urandom));
            3, 4, 5:
            begin
                case ($urandom_range(3))
                    0:       dir = lfsc_pkg::ACT_LEFT;
                    1:       dir = lfsc_pkg::ACT_RIGHT;
                    2:       dir = lfsc_pkg::ACT_CW;
                    default: dir = lfsc_pkg::ACT_CCW;
                endcase
                skip = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(2));
                passes = (skip > 3) ? 4 : int'(skip) + 1;
                repeat ($urandom_range(2, 1))
                    add_tick(dir, SENS_CENTRE, skip);
                repeat (passes)
                begin
                    repeat ($urandom_range(5, 1) + (($urandom_range(7) == 0) ? 12 : 0))
                        add_tick(dir, SENS_CLEAR, skip);
                    if ($urandom_range(4) == 0)
                        add_tick(dir, 4'($urandom), skip);
                    add_tick(dir, line_ahead(dir), skip);
                end
            end
            6:
            begin
                repeat ($urandom_range(2, 1))
                    add_tick(lfsc_pkg::ACT_DELIVERY, SENS_CENTRE, 8'($urandom));
                repeat ($urandom_range(3, 1))
                    add_tick(lfsc_pkg::ACT_DELIVERY,
                             ($urandom_range(3) == 0) ? 4'($urandom) : SENS_CLEAR,
                             8'($urandom));
            end
            7:
                repeat ($urandom_range(3, 1))
                    add_tick(lfsc_pkg::ACT_QUERY, 4'($urandom), 8'($urandom));
            8:
                repeat ($urandom_range(4, 1))
                    add_tick(3'($urandom), 4'($urandom), 8'($urandom));
            default:
            begin
                add_tick(lfsc_pkg::ACT_FOLLOW, SENS_CENTRE, 8'($urandom));
                repeat ($urandom_range(14, 5))
                    add_tick(lfsc_pkg::ACT_FOLLOW, SENS_CLEAR, 8'($urandom));
                add_tick(lfsc_pkg::ACT_FOLLOW, follow_pattern(), 8'($urandom));
            end
        endcase
    endtask

    task automatic queue_random_ticks(int count);
        int goal;
        goal = ticks_queued + count;
        while (ticks_queued < goal)
            add_sequence();
    endtask

    task automatic write_reg(logic [lfsc_pkg::CFG_INDEX_W-1:0] idx, int value);
        @(negedge clk);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= value[lfsc_pkg::CFG_DATA_W-1:0];
        case (idx)
            lfsc_pkg::REG_BASE_SPEED:     cfg_model.base_speed = value[6:0];
            lfsc_pkg::REG_STEER_GAIN:     cfg_model.steer_gain = value[7:0];
            lfsc_pkg::REG_STRAIGHT_LIMIT: cfg_model.straight_lost_limit = value[9:0];
            lfsc_pkg::REG_TURN_LIMIT:     cfg_model.turn_lost_limit = value[9:0];
            lfsc_pkg::REG_EDGE_STEP:      cfg_model.edge_step = value[7:0];
            lfsc_pkg::REG_CORRECTION_CAP: cfg_model.correction_cap = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic set_config(int speed, int gain, int straight, int turn_lim, int step,
                              int cap);
        write_reg(lfsc_pkg::REG_BASE_SPEED, speed);
        write_reg(lfsc_pkg::REG_STEER_GAIN, gain);
        write_reg(lfsc_pkg::REG_STRAIGHT_LIMIT, straight);
        write_reg(lfsc_pkg::REG_TURN_LIMIT, turn_lim);
        write_reg(lfsc_pkg::REG_EDGE_STEP, step);
        write_reg(lfsc_pkg::REG_CORRECTION_CAP, cap);
    endtask

    task automatic wait_until_drained();
        while (pending_ticks.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cfg_model.base_speed          = lfsc_pkg::BASE_SPEED_RESET;
        cfg_model.steer_gain          = lfsc_pkg::STEER_GAIN_RESET;
        cfg_model.straight_lost_limit = lfsc_pkg::STRAIGHT_LIMIT_RESET;
        cfg_model.turn_lost_limit     = lfsc_pkg::TURN_LIMIT_RESET;
        cfg_model.edge_step           = lfsc_pkg::EDGE_STEP_RESET;
        cfg_model.correction_cap      = lfsc_pkg::CORRECTION_CAP_RESET;
        send_idle_pct = 27;
        recv_idle_pct = 52;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_CENTRE, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_INNER_R, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_INNER_L, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_EDGE_L, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_EDGE_R, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_CLEAR, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_JUNCTION_L, 8'd0);
        add_tick(lfsc_pkg::ACT_FOLLOW, SENS_ALL, 8'd0);
        add_tick(lfsc_pkg::ACT_QUERY, SENS_CLEAR, 8'd0);
        add_tick(lfsc_pkg::ACT_QUERY, SENS_ALL, 8'd0);
        add_tick(lfsc_pkg::ACT_QUERY, SENS_JUNCTION_R, 8'd0);
        add_tick(3'b111, SENS_ALL, 8'd255);
        wait_until_drained();
        set_config(61, 255, 2, 40, 255, 127);
        add_tick(lfsc_pkg::ACT_LEFT, SENS_CLEAR, 8'd1);
        add_tick(lfsc_pkg::ACT_LEFT, SENS_INNER_L, 8'd1);
        add_tick(lfsc_pkg::ACT_LEFT, SENS_CLEAR, 8'd1);
        add_tick(lfsc_pkg::ACT_LEFT, SENS_INNER_L, 8'd1);
        add_tick(lfsc_pkg::ACT_RIGHT, SENS_CLEAR, 8'd0);
        add_tick(lfsc_pkg::ACT_RIGHT, SENS_INNER_R, 8'd0);
        add_tick(lfsc_pkg::ACT_CW, SENS_CLEAR, 8'd0);
        add_tick(lfsc_pkg::ACT_CW, SENS_EDGE_R, 8'd0);
        add_tick(lfsc_pkg::ACT_CCW, SENS_CLEAR, 8'd0);
        add_tick(lfsc_pkg::ACT_CCW, SENS_INNER_L, 8'd0);
        add_tick(lfsc_pkg::ACT_DELIVERY, SENS_CENTRE, 8'd0);
        add_tick(lfsc_pkg::ACT_DELIVERY, SENS_CLEAR, 8'd0);
        repeat (3) add_tick(lfsc_pkg::ACT_FOLLOW, SENS_CLEAR, 8'd0);
        wait_until_drained();

        set_config(90, 80, 10, 12, 4, 64);
        queue_random_ticks(120);
        wait_until_drained();

        send_idle_pct = 52;
        recv_idle_pct = 27;
        set_config(127, 255, 1023, 1023, 255, 127);
        repeat (262) add_tick(lfsc_pkg::ACT_FOLLOW, SENS_EDGE_R, 8'($urandom));
        queue_random_ticks(90);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(0, 0, 0, 0, 0, 0);
        queue_random_ticks(60);
        wait_until_drained();

        set_config($urandom_range(127), $urandom_range(255), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(255), $urandom_range(127));
        queue_random_ticks(80);
        wait_until_drained();

        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("line_follow_steering_controller verification clean");
        else
            $display("line_follow_steering_controller verification failed");
        $finish;
    end

endmodule

### files.f
rtl/lfsc_pkg.sv
rtl/lfsc_cfg_regs.sv
rtl/lfsc_steer.sv
rtl/lfsc_tick.sv
rtl/line_follow_steering_controller.sv
bench/tb_line_follow_steering_controller.sv
